// File: rtl/dssc_pkg.sv
// ----------------------------------------------------------------------------
// Drowsiness score classifier package
// Payload types, driver state codes, register indexes and score constants.
// ----------------------------------------------------------------------------
package dssc_pkg;

    localparam int unsigned ATT_W      = 7;
    localparam int unsigned BAND_W     = 24;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SCORE_W    = 16;
    localparam int unsigned SCORE_FRAC = 15;
    localparam int unsigned CUR_W      = 34;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_A2D     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_D2A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D2L     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP    = 3'd7;

    localparam logic [15:0] RST_A2D     = 16'd18022;
    localparam logic [15:0] RST_D2A     = 16'd8192;
    localparam logic [15:0] RST_D2L     = 16'd27853;
    localparam logic [15:0] RST_L2D     = 16'd18022;
    localparam logic [15:0] RST_CONFIRM = 16'd1000;
    localparam logic [31:0] RST_TIMEOUT = 32'd30000;
    localparam logic [15:0] RST_GAP     = 16'd100;
    localparam logic [15:0] RST_BEEP    = 16'd5000;

    localparam logic [1:0] ST_ALERT  = 2'd0;
    localparam logic [1:0] ST_DROWSY = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    localparam logic [1:0] BEEP_NONE   = 2'd0;
    localparam logic [1:0] BEEP_DROWSY = 2'd1;
    localparam logic [1:0] BEEP_LOST   = 2'd3;

    // Band and level weights over the common denominator of ten million.
    localparam logic [CUR_W-1:0] W_THETA  = CUR_W'(12);
    localparam logic [CUR_W-1:0] W_LALPHA = CUR_W'(50);
    localparam logic [CUR_W-1:0] W_HALPHA = CUR_W'(75);
    localparam logic [CUR_W-1:0] W_MED    = CUR_W'(25000);
    localparam logic [CUR_W-1:0] W_LBETA  = CUR_W'(100);
    localparam logic [CUR_W-1:0] W_ATT    = CUR_W'(20000);
    localparam logic [CUR_W-1:0] W_BLINK  = CUR_W'(3000000);

    localparam longint unsigned DEN_UNIT = 64'd10000000;
    localparam longint unsigned K_SUM_S  = 64'd2000000;
    localparam longint unsigned K_SUM_A  = 64'd655360000;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

    localparam int unsigned DIV_STEPS = SCORE_W / 2;
    localparam int unsigned STEP_W    = 3;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [ATT_W-1:0]  attention_level;
        logic [ATT_W-1:0]  meditation_level;
        logic [BAND_W-1:0] theta_power;
        logic [BAND_W-1:0] low_alpha_power;
        logic [BAND_W-1:0] high_alpha_power;
        logic [BAND_W-1:0] low_beta_power;
        logic              blink_seen;
        logic [TIME_W-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [SCORE_W-1:0] drowsy_score;
        logic [1:0]         driver_state;
        logic [1:0]         beep_count;
        logic               timed_out;
    } t_out_item;

    typedef struct packed {
        logic signed [CUR_W-1:0] cur;
        logic [ATT_W-1:0]        attention;
        logic [TIME_W-1:0]       time_ms;
    } t_job;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ATT_W-1:0]   attention;
    } t_ring_entry;

endpackage

// File: rtl/dssc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dssc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dssc_front.sv
// ----------------------------------------------------------------------------
// Drowsiness score front end
// Takes in headset samples and forms the weighted band sum for the queue.
// ----------------------------------------------------------------------------
module dssc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dssc_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_push,
    output dssc_pkg::t_job     o_job
);

    import dssc_pkg::*;

    logic             r_valid;
    t_in_item         r_item;
    logic             w_take;
    logic [CUR_W-1:0] w_pos;
    logic [CUR_W-1:0] w_neg;

    assign o_stall = r_valid & i_q_full;
    assign o_push  = r_valid & ~i_q_full;
    assign w_take  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        w_pos = CUR_W'(r_item.theta_power) * W_THETA
              + CUR_W'(r_item.low_alpha_power) * W_LALPHA
              + CUR_W'(r_item.high_alpha_power) * W_HALPHA
              + CUR_W'(r_item.meditation_level) * W_MED;
        w_neg = CUR_W'(r_item.low_beta_power) * W_LBETA
              + CUR_W'(r_item.attention_level) * W_ATT
              + (r_item.blink_seen ? W_BLINK : '0);
        o_job.cur       = w_pos - w_neg;
        o_job.attention = r_item.attention_level;
        o_job.time_ms   = r_item.time_ms;
    end

endmodule

// File: rtl/dssc_queue.sv
// ----------------------------------------------------------------------------
// Drowsiness score job queue
// Four-entry FIFO between the front end and the scoring back end.
// ----------------------------------------------------------------------------
module dssc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dssc_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output dssc_pkg::t_job o_job
);

    import dssc_pkg::*;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned QP_W    = 2;
    localparam int unsigned QC_W    = 3;

    t_job            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_count;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QP_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QP_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: rtl/dssc_back.sv
// ----------------------------------------------------------------------------
// Drowsiness score back end
// Gap check, history terms, score division, driver state machine and beeps.
// ----------------------------------------------------------------------------
module dssc_back #(
    parameter int unsigned HISTORY_DEPTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dssc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_q_valid,
    input  dssc_pkg::t_job                  i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dssc_pkg::t_out_item             o_result
);

    import dssc_pkg::*;

    localparam int unsigned POS_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SUMS_W = SCORE_W + FILL_W;
    localparam int unsigned SUMA_W = ATT_W + FILL_W;
    localparam longint unsigned DEN = 64'(HISTORY_DEPTH) * DEN_UNIT;
    localparam int unsigned DEN_W  = $clog2(DEN + 1);
    localparam int unsigned RP_W   = DEN_W + 2;
    localparam int unsigned XW     = DEN_W + SCORE_W;
    localparam int unsigned CURD_W = CUR_W + FILL_W + 1;
    localparam int unsigned NUM_W  = CURD_W + SCORE_FRAC + 1;
    localparam int unsigned RING_W = $bits(t_ring_entry);

    localparam logic [NUM_W-1:0] LIM_V  = NUM_W'(64'(SCORE_ONE) * DEN);
    localparam logic [XW-1:0]    HALF_D = XW'(DEN / 2);
    localparam logic [RP_W-1:0]  DEN1   = RP_W'(DEN);
    localparam logic [RP_W-1:0]  DEN2   = RP_W'(2 * DEN);
    localparam logic [RP_W-1:0]  DEN3   = RP_W'(3 * DEN);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_NUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_st;
    logic [2:0] n_st;

    logic [15:0] r_a2d;
    logic [15:0] r_d2a;
    logic [15:0] r_d2l;
    logic [15:0] r_l2d;
    logic [15:0] r_confirm;
    logic [31:0] r_timeout;
    logic [15:0] r_gap;
    logic [15:0] r_beep;

    logic [1:0]        r_cur_st;
    logic [1:0]        r_pend_st;
    logic [TIME_W-1:0] r_confirm_t;
    logic [TIME_W-1:0] r_entry_t;
    logic [TIME_W-1:0] r_beep_t;
    logic [TIME_W-1:0] r_accept_t;
    logic [POS_W-1:0]  r_pos;
    logic [FILL_W-1:0] r_fill;
    logic [SUMS_W-1:0] r_sum_s;
    logic [SUMA_W-1:0] r_sum_a;

    t_job                     r_job;
    logic signed [CURD_W-1:0] r_curd;
    logic signed [NUM_W-1:0]  r_hist;
    logic [DEN_W-1:0]         r_rem;
    logic [SCORE_W-1:0]       r_xlo;
    logic [SCORE_W-1:0]       r_q;
    logic [STEP_W-1:0]        r_step;
    t_out_item                r_res;
    logic                     r_o_valid;
    t_out_item                r_o_result;

    logic [TIME_W-1:0]       w_gap_diff;
    logic                    w_reject;
    logic signed [NUM_W-1:0] w_num;
    logic [XW-1:0]           w_x;
    logic [RP_W-1:0]         w_rp;
    logic [RP_W-1:0]         w_sub;
    logic [1:0]              w_j;
    logic [RING_W-1:0]       w_rdata;
    t_ring_entry             w_old;
    logic [1:0]              w_next;
    logic                    w_take;
    logic [1:0]              w_cur_a;
    logic [TIME_W-1:0]       w_beep_diff;
    logic [TIME_W-1:0]       w_to_diff;
    logic [1:0]              w_beeps;
    logic                    w_timed;
    logic                    w_load;

    logic [1:0]        n_pend_st;
    logic [TIME_W-1:0] n_confirm_t;
    logic [TIME_W-1:0] n_entry_t;
    logic [1:0]        n_cur_st;
    logic [TIME_W-1:0] n_beep_t;
    logic [SUMS_W-1:0] n_sum_s;
    logic [SUMA_W-1:0] n_sum_a;
    logic [POS_W-1:0]  n_pos;
    logic [FILL_W-1:0] n_fill;

    dssc_ram #(
        .WIDTH (RING_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_st == S_UPD),
        .i_waddr (r_pos),
        .i_wdata ({r_q, r_job.attention}),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    assign o_pop    = (r_st == S_IDLE) && i_q_valid;
    assign w_load   = (r_st == S_OUT) && (!r_o_valid || !i_stall);
    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

    assign w_gap_diff = r_job.time_ms - r_accept_t;
    assign w_reject   = w_gap_diff < {16'b0, r_gap};
    assign w_num      = (NUM_W'(r_curd) <<< SCORE_FRAC) + r_hist;
    assign w_x        = XW'($unsigned(w_num)) + HALF_D;

    always_comb begin
        w_rp = {r_rem, r_xlo[SCORE_W-1 -: 2]};
        if (w_rp >= DEN3) begin
            w_j   = 2'd3;
            w_sub = DEN3;
        end else if (w_rp >= DEN2) begin
            w_j   = 2'd2;
            w_sub = DEN2;
        end else if (w_rp >= DEN1) begin
            w_j   = 2'd1;
            w_sub = DEN1;
        end else begin
            w_j   = 2'd0;
            w_sub = '0;
        end
    end

    always_comb begin
        w_old = (FILL_W'(r_pos) < r_fill) ? t_ring_entry'(w_rdata) : '0;
        n_sum_s = r_sum_s - SUMS_W'(w_old.score) + SUMS_W'(r_q);
        n_sum_a = r_sum_a - SUMA_W'(w_old.attention) + SUMA_W'(r_job.attention);
        n_pos  = (r_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : r_pos + POS_W'(1);
        n_fill = (r_fill == FILL_W'(HISTORY_DEPTH)) ? r_fill : r_fill + FILL_W'(1);

        unique case (r_cur_st)
            ST_ALERT: begin
                w_next = (r_q > r_a2d) ? ST_DROWSY : ST_ALERT;
            end
            ST_DROWSY: begin
                if (r_q > r_d2l) begin
                    w_next = ST_LOST;
                end else if (r_q < r_d2a) begin
                    w_next = ST_ALERT;
                end else begin
                    w_next = ST_DROWSY;
                end
            end
            ST_LOST: begin
                w_next = (r_q < r_l2d) ? ST_DROWSY : ST_LOST;
            end
            default: begin
                w_next = r_cur_st;
            end
        endcase

        w_take      = 1'b0;
        n_pend_st   = r_pend_st;
        n_confirm_t = r_confirm_t;
        n_entry_t   = r_entry_t;
        if (w_next != r_cur_st) begin
            if (w_next != r_pend_st) begin
                n_pend_st   = w_next;
                n_confirm_t = r_job.time_ms;
            end else if ((r_job.time_ms - r_confirm_t) > {16'b0, r_confirm}) begin
                w_take    = 1'b1;
                n_entry_t = r_job.time_ms;
            end
        end else begin
            n_pend_st = w_next;
        end
        w_cur_a = w_take ? w_next : r_cur_st;

        w_beep_diff = r_job.time_ms - r_beep_t;
        w_beeps     = BEEP_NONE;
        n_beep_t    = r_beep_t;
        if (w_cur_a == ST_DROWSY && w_beep_diff > {15'b0, r_beep, 1'b0}) begin
            w_beeps  = BEEP_DROWSY;
            n_beep_t = r_job.time_ms;
        end else if (w_cur_a == ST_LOST && w_beep_diff > {17'b0, r_beep[15:1]}) begin
            w_beeps  = BEEP_LOST;
            n_beep_t = r_job.time_ms;
        end

        w_to_diff = w_take ? '0 : (r_job.time_ms - r_entry_t);
        w_timed   = (w_cur_a == ST_DROWSY || w_cur_a == ST_LOST) && (w_to_diff > r_timeout);
        n_cur_st  = w_timed ? ST_ALERT : w_cur_a;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_st = S_PREP;
                end
            end
            S_PREP: begin
                n_st = w_reject ? S_OUT : S_NUM;
            end
            S_NUM: begin
                if (w_num[NUM_W-1] || w_num == '0 || $unsigned(w_num) >= LIM_V) begin
                    n_st = S_UPD;
                end else begin
                    n_st = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_st = S_UPD;
                end
            end
            S_UPD: begin
                n_st = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2d     <= RST_A2D;
            r_d2a     <= RST_D2A;
            r_d2l     <= RST_D2L;
            r_l2d     <= RST_L2D;
            r_confirm <= RST_CONFIRM;
            r_timeout <= RST_TIMEOUT;
            r_gap     <= RST_GAP;
            r_beep    <= RST_BEEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A2D:     r_a2d     <= i_cfg_data[15:0];
                CFG_D2A:     r_d2a     <= i_cfg_data[15:0];
                CFG_D2L:     r_d2l     <= i_cfg_data[15:0];
                CFG_L2D:     r_l2d     <= i_cfg_data[15:0];
                CFG_CONFIRM: r_confirm <= i_cfg_data[15:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_GAP:     r_gap     <= i_cfg_data[15:0];
                CFG_BEEP:    r_beep    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_cur_st    <= ST_ALERT;
            r_pend_st   <= ST_ALERT;
            r_confirm_t <= '0;
            r_entry_t   <= '0;
            r_beep_t    <= '0;
            r_accept_t  <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum_s     <= '0;
            r_sum_a     <= '0;
        end else begin
            r_st <= n_st;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (r_st == S_UPD) begin
                r_cur_st    <= n_cur_st;
                r_pend_st   <= n_pend_st;
                r_confirm_t <= n_confirm_t;
                r_entry_t   <= n_entry_t;
                r_beep_t    <= n_beep_t;
                r_accept_t  <= r_job.time_ms;
                r_pos       <= n_pos;
                r_fill      <= n_fill;
                r_sum_s     <= n_sum_s;
                r_sum_a     <= n_sum_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_st == S_PREP) begin
            r_curd <= $signed(r_job.cur) * $signed({1'b0, FILL_W'(HISTORY_DEPTH)});
            r_hist <= $signed(NUM_W'(r_sum_s) * NUM_W'(K_SUM_S)
                            - NUM_W'(r_sum_a) * NUM_W'(K_SUM_A));
            r_res.accepted     <= 1'b0;
            r_res.drowsy_score <= '0;
            r_res.driver_state <= r_cur_st;
            r_res.beep_count   <= BEEP_NONE;
            r_res.timed_out    <= 1'b0;
        end
        if (r_st == S_NUM) begin
            if (w_num[NUM_W-1] || w_num == '0) begin
                r_q <= '0;
            end else if ($unsigned(w_num) >= LIM_V) begin
                r_q <= SCORE_ONE;
            end else begin
                r_q <= '0;
            end
            r_rem  <= w_x[XW-1:SCORE_W];
            r_xlo  <= w_x[SCORE_W-1:0];
            r_step <= '0;
        end
        if (r_st == S_DIV) begin
            r_rem  <= DEN_W'(w_rp - w_sub);
            r_xlo  <= {r_xlo[SCORE_W-3:0], 2'b00};
            r_q    <= {r_q[SCORE_W-3:0], w_j};
            r_step <= r_step + STEP_W'(1);
        end
        if (r_st == S_UPD) begin
            r_res.accepted     <= 1'b1;
            r_res.drowsy_score <= r_q;
            r_res.driver_state <= n_cur_st;
            r_res.beep_count   <= w_beeps;
            r_res.timed_out    <= w_timed;
        end
        if (w_load) begin
            r_o_result <= r_res;
        end
    end

endmodule

// File: rtl/drowsiness_score_state_classifier.sv
// ----------------------------------------------------------------------------
// Drowsiness score and driver state classifier
// Scores headset samples, tracks alert, drowsy and attention lost states.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  sample    in         i_valid / o_stall      i_item   (t_in_item)
//  result    out        o_valid / i_stall      o_result (t_out_item)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// A sample is registered in the front end and then waits in the queue. The
// back end runs a scored sample through prepare, numerator, the radix-4 score
// divider with its eight steps, update and output; a score that clamps at zero
// or one skips the divider; a sample inside the update gap goes to output.
// Reset is synchronous and active low. A stalled result waits in the output
// register while up to four samples wait in the queue and one in the front.
// ----------------------------------------------------------------------------
module drowsiness_score_state_classifier #(
    parameter int unsigned HISTORY_DEPTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  dssc_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dssc_pkg::t_out_item             o_result,
    input  logic                            i_cfg_we,
    input  logic [dssc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dssc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import dssc_pkg::*;

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_job w_push_job;
    t_job w_pop_job;

    dssc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    dssc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    dssc_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

endmodule
